// ===== sv/spq_pkg.sv =====
// Shared types and constants for the stable sorted priority queue.
`default_nettype none
package spq_pkg;

    // Default number of cells in the sorting row
    localparam int SPQ_CAPACITY = 16;

    // Fixed field widths
    localparam int PRIO_W   = 8;
    localparam int DATA_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Request actions
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Request word
    typedef struct packed {
        logic              action;
        logic [PRIO_W-1:0] priority_req;
        logic [DATA_W-1:0] payload;
    } t_req;

    // Result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PRIO_W-1:0]   out_priority;
        logic [DATA_W-1:0]   out_payload;
        logic [OCC_W-1:0]    occupancy;
    } t_rsp;

    // One stored entry
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } t_entry;

    // Command broadcast to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry entry;
    } t_cell_cmd;

    // What a cell hands to its right neighbor
    typedef struct packed {
        logic   gt;
        t_entry entry;
    } t_cell_link;

endpackage
`default_nettype wire

// ===== sv/spq_stream_if.sv =====
// Valid/ready stream interface carrying one word of a given type.
`default_nettype none
interface spq_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/spq_cell.sv =====
// One cell of the sorting row: holds one entry, shifts right on insert, left on remove.
`default_nettype none
module spq_cell (
    input  wire logic               i_clk,
    input  wire spq_pkg::t_cell_cmd i_cmd,
    input  wire logic               i_in_use,
    input  wire spq_pkg::t_cell_link i_left,
    input  wire spq_pkg::t_entry    i_right,
    output spq_pkg::t_cell_link     o_link
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_gt;

    // Flag a free cell or one whose priority is strictly above the new one
    assign w_gt = !i_in_use || (r_entry.prio > i_cmd.entry.prio);

    // Pick next contents: shift right, take the new entry, shift left or hold
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.enq) begin
            if (i_left.gt) begin
                n_entry = i_left.entry;
            end else if (w_gt) begin
                n_entry = i_cmd.entry;
            end
        end else if (i_cmd.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link.gt    = w_gt;
    assign o_link.entry = r_entry;
endmodule
`default_nettype wire

// ===== sv/stable_sorted_priority_queue.sv =====
// Top level of the stable sorted priority queue: cell row, entry count and result register.
// The queue holds up to CAPACITY entries in a row of cells kept in ascending priority
// order, head in cell 0; an enqueue lands after every entry of lower or equal priority,
// so equal priorities leave in arrival order. Every request yields one result word with
// a status (done, full and dropped, empty), the removed entry on a dequeue and the
// occupancy afterwards. All cells compare against the broadcast request and shift at the
// accepting edge, where the result register also takes the word, so the result is offered
// in the next cycle. A new request is accepted every cycle unless the result register is
// full and not being taken. No clearing pass follows reset; the queue is usable at once.
`default_nettype none
module stable_sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spq_stream_if.sink   i_req,
    spq_stream_if.source o_rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    t_req       w_req;
    logic       w_accept;
    logic       w_full;
    logic       w_empty;
    t_cell_cmd  w_cmd;
    t_cell_link w_link [CAPACITY];

    assign w_req    = i_req.data;
    assign w_accept = i_req.valid && i_req.ready;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // Accept while the result register is free or being drained
    assign i_req.ready = !r_valid || o_rsp.ready;

    // Broadcast the command to the row
    assign w_cmd.enq         = w_accept && (w_req.action == ACT_ENQ) && !w_full;
    assign w_cmd.deq         = w_accept && (w_req.action == ACT_DEQ) && !w_empty;
    assign w_cmd.entry.prio  = w_req.priority_req;
    assign w_cmd.entry.data  = w_req.payload;

    // Build the cell row
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_cell_link w_left;
            t_entry     w_right;
            logic       w_in_use;

            assign w_in_use = (r_count > CNT_W'(gi));

            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid
                assign w_left = w_link[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_link[gi+1].entry;
            end

            spq_cell u_cell (
                .i_clk    (i_clk),
                .i_cmd    (w_cmd),
                .i_in_use (w_in_use),
                .i_left   (w_left),
                .i_right  (w_right),
                .o_link   (w_link[gi])
            );
        end
    endgenerate

    // Advance the entry count
    always_comb begin
        n_count = r_count;
        if (w_cmd.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.deq) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Form the result word
    always_comb begin
        n_rsp              = '0;
        n_rsp.occupancy    = OCC_W'(n_count);
        if (w_req.action == ACT_ENQ) begin
            n_rsp.status = w_full ? ST_FULL : ST_DONE;
        end else if (w_empty) begin
            n_rsp.status = ST_EMPTY;
        end else begin
            n_rsp.status       = ST_DONE;
            n_rsp.out_priority = w_link[0].entry.prio;
            n_rsp.out_payload  = w_link[0].entry.data;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.data  = r_rsp;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_link[0].entry.prio <= w_link[1].entry.prio))
        else $error("head cells out of order");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req.action == ACT_DEQ && w_empty)
            |=> (o_rsp.valid && o_rsp.data.status == ST_EMPTY && r_count == '0))
        else $error("empty dequeue not reported");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> (r_count == $past(r_count)))
        else $error("count moved without a request");
`endif
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the stable sorted priority queue.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = SPQ_CAPACITY;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 203;
    localparam int DRAIN_LIMIT  = 5000;

    // Track queue contents and the result words still owed by the block
    class pq_scoreboard;
        t_entry held_entries[$];
        t_rsp   due_results[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Apply one accepted request to the queue copy and queue its result
        function void note_request(t_req w);
            t_entry e;
            t_rsp   r;
            int     pos;
            r = '0;
            if (w.action == ACT_ENQ) begin
                if (held_entries.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // land after every entry of lower or equal priority
                    pos = 0;
                    while (pos < held_entries.size() &&
                           held_entries[pos].prio <= w.priority_req)
                        pos++;
                    e.prio = w.priority_req;
                    e.data = w.payload;
                    held_entries.insert(pos, e);
                    r.status = ST_DONE;
                end
            end else if (held_entries.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                e = held_entries.pop_front();
                r.status       = ST_DONE;
                r.out_priority = e.prio;
                r.out_payload  = e.data;
            end
            r.occupancy = OCC_W'(held_entries.size());
            due_results.push_back(r);
        endfunction

        // Compare one accepted result word with the oldest one owed
        function void check_result(t_rsp got);
            t_rsp want;
            if (due_results.size() == 0) begin
                $display("%0t: result word with none owed: %p", $time, got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.out_priority !== want.out_priority) begin
                $display("%0t: out_priority expected %0d actual %0d",
                         $time, want.out_priority, got.out_priority);
                errors++;
            end
            if (got.out_payload !== want.out_payload) begin
                $display("%0t: out_payload expected %h actual %h",
                         $time, want.out_payload, got.out_payload);
                errors++;
            end
            if (got.occupancy !== want.occupancy) begin
                $display("%0t: occupancy expected %0d actual %0d",
                         $time, want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    spq_stream_if #(.t_data(t_req)) req_if ();
    spq_stream_if #(.t_data(t_rsp)) rsp_if ();

    pq_scoreboard board = new();

    // Odds of an idle burst per word on either side; zero turns idling off
    int unsigned idle_odds;

    // Directed fill: extremes, a run of equal priorities, assorted middles
    logic [PRIO_W-1:0] fill_prio [16] = '{8'd255, 8'd0, 8'd7, 8'd7, 8'd7, 8'd128, 8'd1,
                                          8'd254, 8'd7, 8'd0, 8'd255, 8'd64, 8'd127,
                                          8'd200, 8'd3, 8'd7};
    logic [DATA_W-1:0] fill_data [16] = '{16'hffff, 16'h0000, 16'haaaa, 16'h5555,
                                          16'h1234, 16'h8000, 16'h0001, 16'hfffe,
                                          16'h7777, 16'h0f0f, 16'hf0f0, 16'h4321,
                                          16'h00ff, 16'hff00, 16'hc3c3, 16'h3c3c};
    int unsigned enq_pct_by_phase [PHASES] = '{90, 50, 20, 80, 60, 25, 85, 50};

    logic              rnd_act;
    logic [PRIO_W-1:0] rnd_prio;
    logic [PRIO_W-1:0] tie_base;
    int unsigned       enq_pct;
    int unsigned       prio_mode;
    int                drain_wait;
    int unsigned       sink_gap_left;

    stable_sorted_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop on a hung run
    initial begin
        #5_000_000;
        $display("** stable_sorted_priority_queue: FAILED **");
        $finish;
    end

    // Offer one request word, hold it until taken, then maybe idle a while
    task automatic push_item(input logic act, input logic [PRIO_W-1:0] prio,
                             input logic [DATA_W-1:0] data);
        t_req w;
        int unsigned gap;
        w.action       = act;
        w.priority_req = prio;
        w.payload      = data;
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_request(w);
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            gap = $urandom_range(1, 11);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every owed result word has come back
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Result side: check taken words, stall ready in random bursts
    initial begin
        rsp_if.ready <= 1'b0;
        sink_gap_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready)
                board.check_result(rsp_if.data);
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (sink_gap_left != 0) begin
                sink_gap_left--;
                rsp_if.ready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                sink_gap_left = $urandom_range(1, 11) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Request side: reset, directed words, random phases, then wrap up
    initial begin
        idle_odds = 4;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // dequeue on an empty queue, with every request bit set
        push_item(ACT_DEQ, 8'hff, 16'hffff);
        // fill to capacity, then offer one more with the lowest priority
        for (int i = 0; i < 16; i++)
            push_item(ACT_ENQ, fill_prio[i], fill_data[i]);
        push_item(ACT_ENQ, 8'd0, 16'hbeef);
        // take a few heads: lowest priorities, equal ones in arrival order
        repeat (6) push_item(ACT_DEQ, 8'h00, 16'h0000);
        wait_for_results();

        // Random phases: fill-heavy, drain-heavy and balanced mixes
        for (int ph = 0; ph < PHASES; ph++) begin
            enq_pct   = enq_pct_by_phase[ph];
            prio_mode = ph % 3;
            tie_base  = 8'($urandom_range(0, 252));
            idle_odds = (ph == 3 || ph == PHASES - 1) ? 0 : 3 + ph;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                rnd_act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
                case (prio_mode)
                    0: begin
                        rnd_prio = 8'($urandom_range(0, 255));
                    end
                    1: begin
                        // narrow band: many equal priorities
                        rnd_prio = tie_base + 8'($urandom_range(0, 3));
                    end
                    default: begin
                        if ($urandom_range(0, 1) == 1)
                            rnd_prio = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
                        else
                            rnd_prio = 8'($urandom);
                    end
                endcase
                push_item(rnd_act, rnd_prio, 16'($urandom));
            end
            if (ph != PHASES - 1)
                wait_for_results();
        end

        // Drain what is owed, then give stray words time to show up
        req_if.valid <= 1'b0;
        drain_wait = 0;
        do begin
            @(posedge i_clk);
            drain_wait++;
        end while (board.pending() != 0 && drain_wait < DRAIN_LIMIT);
        repeat (8) @(posedge i_clk);

        if (board.pending() != 0) begin
            $display("%0t: %0d result words never came", $time, board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("** stable_sorted_priority_queue: PASSED **");
        end else begin
            $display("** stable_sorted_priority_queue: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
